// File: design/rmeu_pkg.sv
package rmeu_pkg;

   typedef enum logic [3:0] {
      OP_DATA   = 4'd0,
      OP_LOAD   = 4'd1,
      OP_ADD    = 4'd2,
      OP_SUB    = 4'd3,
      OP_MUL    = 4'd4,
      OP_DIV    = 4'd5,
      OP_PUT    = 4'd6,
      OP_GET    = 4'd7,
      OP_GOTO   = 4'd8,
      OP_ZGOTO  = 4'd9,
      OP_NZGOTO = 4'd10,
      OP_PRINT  = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_SAT     = 2'd3
   } status_type;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // Decoded instruction as it sits in the queue between front and back.
   typedef struct packed {
      logic [3:0]  mode;
      logic [31:0] immediate;
      logic [2:0]  src_a;
      logic [2:0]  src_b;
      logic [2:0]  dest_reg;
      logic [7:0]  address;
      logic        is_arith;
      logic        is_jump;
   } instr_type;

   typedef struct packed {
      logic [31:0] value;
      logic        jump_taken;
      logic [7:0]  jump_target;
      logic        print_valid;
      logic [1:0]  status;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_DIV,
      BK_DIVFIX,
      BK_OUT
   } back_state_type;

   // Saturate a 66-bit signed value to 32 bits.
   function automatic logic [32:0] clip32(input logic signed [65:0] x);
      logic [32:0] r;
      if (x > 66'sh0_7FFF_FFFF) begin
         r = {1'b1, SAT_MAX};
      end else if (x < -66'sh0_8000_0000) begin
         r = {1'b1, SAT_MIN};
      end else begin
         r = {1'b0, x[31:0]};
      end
      return r;
   endfunction

endpackage

// File: design/rmeu_front.sv
module rmeu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [3:0]          in_mode,
   input  logic [31:0]         in_immediate,
   input  logic [2:0]          in_src_a,
   input  logic [2:0]          in_src_b,
   input  logic [2:0]          in_dest_reg,
   input  logic [7:0]          in_address,
   output logic                q_valid,
   input  logic                q_ready,
   output rmeu_pkg::instr_type q_data
);
   import rmeu_pkg::*;

   // Two-entry queue that decouples classification from execution.
   instr_type slot_ff [2];
   instr_type slot_in;
   logic      wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic      push, pop;

   always_comb begin
      slot_in           = '0;
      slot_in.mode      = in_mode;
      slot_in.immediate = in_immediate;
      slot_in.src_a     = in_src_a;
      slot_in.src_b     = in_src_b;
      slot_in.dest_reg  = in_dest_reg;
      slot_in.address   = in_address;
      slot_in.is_arith  = (in_mode == OP_ADD) || (in_mode == OP_SUB)
                          || (in_mode == OP_MUL) || (in_mode == OP_DIV);
      slot_in.is_jump   = (in_mode == OP_GOTO) || (in_mode == OP_ZGOTO)
                          || (in_mode == OP_NZGOTO);
   end

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_data   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("pop from empty queue");
`endif

endmodule

// File: design/rmeu_back.sv
module rmeu_back #(
   parameter int NUM_REGS  = 8,
   parameter int MEM_WORDS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  rmeu_pkg::instr_type  q_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rmeu_pkg::result_type out_data
);
   import rmeu_pkg::*;

   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   back_state_type state_ff, state_in;
   instr_type      ins_ff;
   logic [31:0]    regs_ff [NUM_REGS];
   logic [31:0]    mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] valid_ff;
   logic [31:0]    mem_rd_ff;
   logic [31:0]    a_ff, b_ff;
   logic signed [63:0] prod_ff;
   // Divider: restoring, magnitude based, one quotient bit a cycle.
   logic [63:0]    dvd_ff;
   logic [32:0]    rem_ff;
   logic [31:0]    dvs_ff;
   logic [5:0]     cnt_ff;
   logic           neg_ff;
   result_type     res_ff, res_in;
   logic           out_valid_ff;

   logic        addr_ok;
   logic [AW-1:0] addr_idx;
   logic          reg_we;
   logic [31:0]   reg_wd;

   assign addr_ok  = ({24'd0, q_data.address} < 32'(MEM_WORDS));
   assign addr_idx = AW'(q_data.address);

   function automatic logic [31:0] rd_reg(input logic [2:0] idx,
                                          input logic [31:0] r [NUM_REGS]);
      logic [31:0] v;
      v = '0;
      if ({29'd0, idx} < 32'(NUM_REGS)) v = r[RW'(idx)];
      return v;
   endfunction

   logic [32:0] rem_try;
   logic [32:0] clip_add, clip_sub, clip_mul, clip_div;
   logic signed [63:0] mul_q;
   logic signed [65:0] qsigned;

   assign rem_try = {rem_ff[31:0], dvd_ff[63]} - {1'b0, dvs_ff};

   always_comb begin
      clip_add = clip32(66'(signed'(a_ff)) + 66'(signed'(b_ff)));
      clip_sub = clip32(66'(signed'(a_ff)) - 66'(signed'(b_ff)));
      // Arithmetic shift floors toward minus infinity.
      mul_q    = prod_ff >>> 16;
      clip_mul = clip32(66'(mul_q));
      qsigned  = neg_ff ? -66'(signed'({1'b0, dvd_ff[63:0]}))
                        : 66'(signed'({1'b0, dvd_ff[63:0]}));
      clip_div = clip32(qsigned);
   end

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      reg_we   = 1'b0;
      reg_wd   = '0;
      q_ready  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) state_in = BK_READ;
         end
         BK_READ: begin
            res_in = '0;
            unique case (ins_ff.mode) inside
               OP_DATA: begin
                  res_in.value = ins_ff.immediate;
                  state_in = BK_OUT;
               end
               OP_LOAD: begin
                  res_in.value = ins_ff.immediate;
                  reg_we = 1'b1;
                  reg_wd = ins_ff.immediate;
                  state_in = BK_OUT;
               end
               OP_ADD: begin
                  res_in.value  = clip_add[31:0];
                  res_in.status = clip_add[32] ? ST_SAT : ST_OK;
                  reg_we = 1'b1;
                  reg_wd = clip_add[31:0];
                  state_in = BK_OUT;
               end
               OP_SUB: begin
                  res_in.value  = clip_sub[31:0];
                  res_in.status = clip_sub[32] ? ST_SAT : ST_OK;
                  reg_we = 1'b1;
                  reg_wd = clip_sub[31:0];
                  state_in = BK_OUT;
               end
               OP_MUL: state_in = BK_MUL;
               OP_DIV: begin
                  if (b_ff == '0) begin
                     res_in.value  = a_ff[31] ? SAT_MIN
                                   : (a_ff == '0) ? 32'd0 : SAT_MAX;
                     res_in.status = ST_DIVZERO;
                     reg_we = 1'b1;
                     reg_wd = res_in.value;
                     state_in = BK_OUT;
                  end else begin
                     state_in = BK_DIV;
                  end
               end
               OP_PUT: begin
                  res_in.value = a_ff;
                  state_in = BK_OUT;
               end
               OP_GET: begin
                  if (b_ff[0]) begin
                     res_in.value = mem_rd_ff;
                     reg_we = 1'b1;
                     reg_wd = mem_rd_ff;
                  end else begin
                     res_in.status = ST_EMPTY;
                  end
                  state_in = BK_OUT;
               end
               OP_GOTO, OP_ZGOTO, OP_NZGOTO: begin
                  res_in.value = Q_ONE;
                  if (ins_ff.mode == OP_GOTO
                      || (ins_ff.mode == OP_ZGOTO && a_ff == '0)
                      || (ins_ff.mode == OP_NZGOTO && a_ff != '0)) begin
                     res_in.jump_taken  = 1'b1;
                     res_in.jump_target = ins_ff.address;
                  end
                  state_in = BK_OUT;
               end
               OP_PRINT: begin
                  res_in.value = a_ff;
                  res_in.print_valid = 1'b1;
                  state_in = BK_OUT;
               end
               default: state_in = BK_OUT;
            endcase
         end
         BK_MUL: begin
            res_in.value  = clip_mul[31:0];
            res_in.status = clip_mul[32] ? ST_SAT : ST_OK;
            reg_we = 1'b1;
            reg_wd = clip_mul[31:0];
            state_in = BK_OUT;
         end
         BK_DIV: begin
            if (cnt_ff == 6'd0) state_in = BK_DIVFIX;
         end
         BK_DIVFIX: begin
            res_in.value  = clip_div[31:0];
            res_in.status = clip_div[32] ? ST_SAT : ST_OK;
            reg_we = 1'b1;
            reg_wd = clip_div[31:0];
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (out_ready) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Registers a and b are captured when a request is accepted in idle, for use in the read
   // stage; b's low bit also carries the memory valid mark for get.
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && q_valid) begin
         ins_ff    <= q_data;
         mem_rd_ff <= mem[addr_idx];
      end
      if (state_ff == BK_IDLE && q_valid && q_data.mode == OP_PUT && addr_ok) begin
         mem[addr_idx] <= rd_reg(q_data.src_a, regs_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && q_valid) begin
         a_ff <= rd_reg(q_data.src_a, regs_ff);
         b_ff <= (q_data.mode == OP_GET)
                 ? {31'd0, addr_ok && valid_ff[addr_idx]}
                 : rd_reg(q_data.src_b, regs_ff);
      end
      if (state_ff == BK_READ) begin
         prod_ff <= 64'(signed'(a_ff)) * 64'(signed'(b_ff));
         dvd_ff  <= {16'd0, (a_ff[31] ? -a_ff : a_ff), 16'd0};
         dvs_ff  <= b_ff[31] ? -b_ff : b_ff;
         rem_ff  <= '0;
         neg_ff  <= a_ff[31] ^ b_ff[31];
         cnt_ff  <= 6'd63;
      end else if (state_ff == BK_DIV) begin
         if (!rem_try[32]) begin
            rem_ff <= rem_try;
            dvd_ff <= {dvd_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], dvd_ff[63]};
            dvd_ff <= {dvd_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 6'd1;
      end
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= (state_in == BK_OUT);
         if (state_ff == BK_IDLE && q_valid && q_data.mode == OP_PUT && addr_ok) begin
            valid_ff[addr_idx] <= 1'b1;
         end
         if (reg_we && ({29'd0, ins_ff.dest_reg} < 32'(NUM_REGS))) begin
            regs_ff[RW'(ins_ff.dest_reg)] <= reg_wd;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = res_ff;

   logic unused;
   assign unused = ^{ins_ff.is_arith, ins_ff.is_jump, rem_ff[32]};

`ifndef ASSERT_OFF
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> state_ff == BK_OUT) else $error("result shown outside output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("result dropped");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DIV && cnt_ff == 6'd0 |=> state_ff == BK_DIVFIX)
      else $error("divider did not finish");
`endif

endmodule

// File: design/register_machine_execute_unit_core.sv
// Executes one register-machine instruction per request on an internal register file of
// NUM_REGS Q16.16 words and a MEM_WORDS-word data memory with per-word valid marks, and
// returns exactly one result per request. A front queue of two entries accepts requests
// while the back end works. Most instructions pass through the read and output states of
// the back end; multiply adds a multiply state; divide runs a one-bit-per-cycle restoring
// divider over 64 quotient bits, then a fix-up state, before output. The back end takes a
// new request only once the last result is taken. A stalled result holds the back end for
// as long as the stall lasts. The divider loop sets the worst-case rate.
module register_machine_execute_unit_core #(
   parameter int NUM_REGS  = 8,
   parameter int MEM_WORDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[3:0], immediate[35:4], src_a[38:36], src_b[41:39], dest_reg[44:42],
   // address[52:45], zero fill to 56 bits
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value[31:0], jump_taken[32], jump_target[40:33], print_valid[41],
   // status[43:42], zero fill to 48 bits
   output logic [47:0] rsp_tdata
);
   import rmeu_pkg::*;

   instr_type  q_data;
   logic       q_valid, q_ready;
   result_type res;

   rmeu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_mode     (req_tdata[3:0]),
      .in_immediate(req_tdata[35:4]),
      .in_src_a    (req_tdata[38:36]),
      .in_src_b    (req_tdata[41:39]),
      .in_dest_reg (req_tdata[44:42]),
      .in_address  (req_tdata[52:45]),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_data      (q_data)
   );

   rmeu_back #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (res)
   );

   assign rsp_tdata = {4'd0, res.status, res.print_valid, res.jump_target,
                       res.jump_taken, res.value};

endmodule
